>>> rtl/thermistor_pkg.sv
// Shared types, constants and the resistance table of the thermistor block.
`timescale 1ns / 1ps
`default_nettype none
package thermistor_pkg;

  localparam int unsigned SeriesW = 20;
  localparam logic [SeriesW-1:0] SeriesReset = 20'd10000;
  localparam int unsigned TableN = 37;
  localparam int unsigned IdxW = 6;
  localparam logic signed [7:0] TempCold = -8'sd55;
  localparam logic signed [7:0] TempHot = 8'sd125;

  // Averaging ring depth; the mean is taken by a shift, so it stays a power of two.
  localparam int unsigned AvgDepth = 16;
  localparam int unsigned AvgLog2 = 4;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RING,
    ST_SEARCH,
    ST_DIVIDE,
    ST_DONE
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic ring;
    logic step;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic search_done;
    logic div_done;
  } status_t;

  // Resistance in ohms of table entry k (5 degree steps from -55 C).
  function automatic logic [19:0] table_ohms(input logic [IdxW-1:0] k);
    logic [19:0] r;
    case (k)
      6'd0: r = 20'd772850; 6'd1: r = 20'd549380; 6'd2: r = 20'd395070;
      6'd3: r = 20'd287220; 6'd4: r = 20'd210990; 6'd5: r = 20'd156520;
      6'd6: r = 20'd117150; 6'd7: r = 20'd88541; 6'd8: r = 20'd67433;
      6'd9: r = 20'd51815; 6'd10: r = 20'd40099; 6'd11: r = 20'd31283;
      6'd12: r = 20'd24569; 6'd13: r = 20'd19438; 6'd14: r = 20'd15475;
      6'd15: r = 20'd12403; 6'd16: r = 20'd10000; 6'd17: r = 20'd8110;
      6'd18: r = 20'd6615; 6'd19: r = 20'd5425; 6'd20: r = 20'd4472;
      6'd21: r = 20'd3707; 6'd22: r = 20'd3087; 6'd23: r = 20'd2583;
      6'd24: r = 20'd2171; 6'd25: r = 20'd1832; 6'd26: r = 20'd1554;
      6'd27: r = 20'd1322; 6'd28: r = 20'd1130; 6'd29: r = 20'd969;
      6'd30: r = 20'd835; 6'd31: r = 20'd721; 6'd32: r = 20'd623;
      6'd33: r = 20'd544; 6'd34: r = 20'd475; 6'd35: r = 20'd416;
      6'd36: r = 20'd365;
      default: r = 20'd365;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/thermistor_averaging_temperature.sv
// Top level of the thermistor averaging temperature block.
// Usage: one 12-bit ADC sample is offered on sample_i with in_valid_i and
// in_ready_o; a beat is taken when both are high. Each sample yields one result
// beat (temperature_o, mean_sample_o, below_range_o, above_range_o) on
// out_valid_o / out_ready_i. The 16-sample mean is turned into a divider
// resistance ratio, bracketed in the 37-entry table and interpolated.
// From the input beat to a valid result the steps are: the ring update and
// operand set-up, the serial table search at one entry per cycle, the start of
// the quotient, and the quotient steps, which a clamped result skips. Items are
// handled one at a time; the next sample can be taken in the cycle after the
// result beat leaves. While a result waits on a stalled receiver no new sample
// is taken. Reset empties the averaging ring and sets series resistance to
// 10000 ohms; the first sample afterwards fills the whole ring.
// The user must write series_resistance over APB at address 0 only while the
// block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module thermistor_averaging_temperature (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [11:0]       sample_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic signed [7:0]      temperature_o,
  output logic [11:0]            mean_sample_o,
  output logic                   below_range_o,
  output logic                   above_range_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [1:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  thermistor_pkg::cmd_t    cmd;
  thermistor_pkg::status_t sts;
  logic [19:0] series_q;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {12'd0, series_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      series_q <= thermistor_pkg::SeriesReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      series_q <= pwdata[19:0];
    end
  end

  thermistor_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_ready_i, .out_valid_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  thermistor_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .sample_i, .series_i(series_q),
    .temperature_o, .mean_sample_o, .below_range_o, .above_range_o
  );

endmodule
`default_nettype wire

>>> rtl/thermistor_ctrl.sv
// Sequencing state machine of the thermistor block.
`timescale 1ns / 1ps
`default_nettype none
module thermistor_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  input  wire thermistor_pkg::status_t sts_i,
  output thermistor_pkg::cmd_t        cmd_o
);

  thermistor_pkg::state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      thermistor_pkg::ST_IDLE:   if (in_valid_i) state_d = thermistor_pkg::ST_RING;
      thermistor_pkg::ST_RING:   state_d = thermistor_pkg::ST_SEARCH;
      thermistor_pkg::ST_SEARCH: if (sts_i.search_done) state_d = thermistor_pkg::ST_DIVIDE;
      thermistor_pkg::ST_DIVIDE: if (sts_i.div_done) state_d = thermistor_pkg::ST_DONE;
      thermistor_pkg::ST_DONE:   if (out_ready_i) state_d = thermistor_pkg::ST_IDLE;
      default:                   state_d = thermistor_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      thermistor_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      thermistor_pkg::ST_RING: begin
        cmd_o.ring = 1'b1;
      end
      thermistor_pkg::ST_SEARCH: begin
        cmd_o.step = 1'b1;
        cmd_o.div_start = sts_i.search_done;
      end
      thermistor_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cmd_o.finish = sts_i.div_done;
      end
      thermistor_pkg::ST_DONE: begin
        out_valid_o = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= thermistor_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/thermistor_dp.sv
// Datapath: sample ring, mean, table search and interpolation divider.
`timescale 1ns / 1ps
`default_nettype none
module thermistor_dp (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire thermistor_pkg::cmd_t    cmd_i,
  output thermistor_pkg::status_t      sts_o,
  input  wire logic [11:0]             sample_i,
  input  wire logic [19:0]             series_i,
  output logic signed [7:0]            temperature_o,
  output logic [11:0]                  mean_sample_o,
  output logic                         below_range_o,
  output logic                         above_range_o
);

  localparam int unsigned PtrW = thermistor_pkg::AvgLog2;
  localparam int unsigned SumW = 12 + thermistor_pkg::AvgLog2;
  localparam logic [PtrW:0] LastPtr = (PtrW + 1)'(thermistor_pkg::AvgDepth - 1);

  // Ring memory and running sum.
  logic [11:0]     ring_mem [thermistor_pkg::AvgDepth];
  logic [11:0]     old_q, smp_q;
  logic [PtrW-1:0] ptr_q;
  logic [SumW-1:0] sum_q;
  logic            primed_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      old_q <= ring_mem[ptr_q];
      smp_q <= sample_i;
    end
    if (cmd_i.ring) begin
      ring_mem[ptr_q] <= smp_q;
    end
  end

  // The first sample stands for the whole ring until each slot is written once.
  logic [PtrW:0] fill_q;
  logic [11:0] smp_q0_q;
  logic [SumW-1:0] sum_next;
  always_comb begin
    if (!primed_q) sum_next = SumW'(smp_q) << thermistor_pkg::AvgLog2;
    else sum_next = sum_q - SumW'(fill_q <= LastPtr ? smp_q0_q : old_q) + SumW'(smp_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      sum_q <= '0;
      primed_q <= 1'b0;
      fill_q <= '0;
      smp_q0_q <= '0;
    end else if (cmd_i.ring) begin
      sum_q <= sum_next;
      primed_q <= 1'b1;
      if (!primed_q) smp_q0_q <= smp_q;
      if (fill_q <= LastPtr) fill_q <= fill_q + 1'b1;
      ptr_q <= (ptr_q == LastPtr[PtrW-1:0]) ? '0 : ptr_q + 1'b1;
    end
  end

  // Mean: the ring depth is a power of two, so the sum is simply shifted.
  logic [11:0] avg;
  assign avg = sum_q[SumW-1:thermistor_pkg::AvgLog2];

  // Resistance comparison by cross products: top = series*avg, rest = 4095-avg.
  logic [31:0] top_q;
  logic [11:0] rest_q;
  logic [11:0] avg_q;
  logic [thermistor_pkg::IdxW-1:0] k_q;
  logic [1:0] phase_q;
  logic [31:0] prod;
  logic        full_q;
  assign prod = 32'(thermistor_pkg::table_ohms(k_q)) * 32'(rest_q);

  logic srch_done_q;
  logic below_q, above_q;
  assign sts_o.search_done = srch_done_q;

  // Divider registers.
  logic [35:0] num_q, rem_q;
  logic [31:0] den_q;
  logic [5:0]  dcnt_q;
  logic [2:0]  quo_q;
  logic signed [7:0] tbase_q;
  assign sts_o.div_done = (dcnt_q == 6'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      srch_done_q <= 1'b0;
      k_q <= '0;
      dcnt_q <= '0;
      avg_q <= '0;
      top_q <= '0;
      rest_q <= '0;
      full_q <= 1'b0;
      below_q <= 1'b0;
      above_q <= 1'b0;
    end else begin
      if (cmd_i.ring) begin
        phase_q <= 2'd0;
        srch_done_q <= 1'b0;
        k_q <= '0;
      end else if (cmd_i.step && !srch_done_q) begin
        case (phase_q)
          2'd0: begin
            avg_q <= avg;
            top_q <= 32'(series_i) * 32'(avg);
            rest_q <= 12'd4095 - avg;
            full_q <= (avg == 12'd4095);
            phase_q <= 2'd1;
          end
          2'd1: begin
            // Coldest entry: a full-scale mean or a resistance at or above it.
            above_q <= 1'b0;
            below_q <= full_q || top_q >= prod;
            if (full_q || top_q >= prod) begin
              srch_done_q <= 1'b1;
            end else begin
              k_q <= k_q + 1'b1;
              phase_q <= 2'd2;
            end
          end
          default: begin
            if (top_q > prod) begin
              srch_done_q <= 1'b1;
            end else if (k_q == 6'(thermistor_pkg::TableN - 1)) begin
              above_q <= 1'b1;
              srch_done_q <= 1'b1;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        endcase
      end
      // Divider start: num = 5*(R_{k-1}*rest - top), den = (R_{k-1}-R_k)*rest.
      if (cmd_i.div_start) begin
        if (below_q || above_q) dcnt_q <= 6'd0;
        else dcnt_q <= 6'd4;
      end else if (cmd_i.div_step && dcnt_q != 6'd0) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
    end
  end

  // Interpolation operands and shift-subtract quotient (quotient below 5, 3 bits).
  logic [31:0] hi_prod_q, lo_prod_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      hi_prod_q <= prod;
      lo_prod_q <= hi_prod_q;
    end
    if (cmd_i.div_start) begin
      den_q <= lo_prod_q - prod;
      num_q <= 36'(lo_prod_q - top_q) * 36'd5;
      rem_q <= '0;
      quo_q <= '0;
      tbase_q <= 8'(-55 + 5 * int'(k_q) - 5);
    end else if (cmd_i.div_step && dcnt_q != 6'd0) begin
      if (dcnt_q == 6'd4) begin
        rem_q <= num_q;
      end else begin
        // Restoring steps over quotient bits 2..0 with remainder scaled by den.
        if ({4'd0, rem_q} >= ({5'd0, den_q} << (dcnt_q - 6'd1))) begin
          rem_q <= rem_q - 36'({4'd0, den_q} << (dcnt_q - 6'd1));
          quo_q[2'(dcnt_q - 6'd1)] <= 1'b1;
        end
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      mean_sample_o <= avg_q;
      below_range_o <= below_q;
      above_range_o <= above_q;
      if (below_q) temperature_o <= thermistor_pkg::TempCold;
      else if (above_q) temperature_o <= thermistor_pkg::TempHot;
      else if (tbase_q >= 0 || rem_q == '0) temperature_o <= tbase_q + 8'(quo_q);
      else temperature_o <= tbase_q + 8'(quo_q) + 8'sd1;
    end
  end

endmodule
`default_nettype wire
